// ===== src/mrtm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrtm_pkg
// Shared types, codes and helpers for the MPU region table manager.
// ----------------------------------------------------------------------------
package mrtm_pkg;

  localparam int DEF_REGION_SLOTS = 8;

  localparam logic [31:0] RASR_XN       = 32'h1000_0000;
  localparam logic [31:0] RASR_ATTR     = 32'h000F_0000;
  localparam logic [31:0] RASR_EN       = 32'h0000_0001;
  localparam logic [31:0] RBAR_LOW_MASK = 32'h0000_001F;

  localparam logic [1:0] RT_NONE = 2'd0;
  localparam logic [1:0] RT_RO   = 2'd1;
  localparam logic [1:0] RT_RW   = 2'd2;

  localparam logic [2:0] AP_NONE    = 3'd0;
  localparam logic [2:0] AP_PRW     = 3'd1;
  localparam logic [2:0] AP_PRW_URO = 3'd2;
  localparam logic [2:0] AP_PRW_URW = 3'd3;
  localparam logic [2:0] AP_PRO     = 3'd5;
  localparam logic [2:0] AP_PRO_URO = 3'd6;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_DEL    = 2'd1,
    OP_COMMIT = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_PARAM = 2'd1,
    ST_MISS  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_END,
    S_SCAN,
    S_FIND,
    S_SHIFT,
    S_EMIT,
    S_OUT
  } state_t;

  typedef struct packed {
    logic in_span;
    logic equal;
  } unit_flags_t;

  function automatic logic [2:0] ap_code(input logic [1:0] p, input logic [1:0] u);
    logic [2:0] ap;
    ap = AP_NONE;
    if (p == RT_RW) begin
      if (u == RT_RW)        ap = AP_PRW_URW;
      else if (u == RT_RO)   ap = AP_PRW_URO;
      else if (u == RT_NONE) ap = AP_PRW;
    end else if (p == RT_RO) begin
      ap = (u == RT_RO) ? AP_PRO_URO : AP_PRO;
    end
    return ap;
  endfunction

  // 2^(size+1) - 1; a size of 31 gives all ones
  function automatic logic [31:0] span_mask(input logic [4:0] size);
    logic [5:0] amt;
    amt = {1'b0, size} + 6'd1;
    return ~(32'hFFFF_FFFF << amt);
  endfunction

endpackage

// ===== src/mpu_region_table_manager.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpu_region_table_manager
// Region table with add, delete and commit; one slot at a time through a sequencer.
// ----------------------------------------------------------------------------
// Add computes the region end, then makes two range checks per valid slot
// through one comparator; delete finds the slot, then shifts the later slots
// down one slot per cycle; each result item is then held in S_OUT. Commit
// emits REGION_SLOTS items, each through S_EMIT and S_OUT. One item at a time:
// in_tready is high only while idle. Reset (rst_n low, synchronous) clears
// all slot valid bits; slot payload is not cleared.
// ----------------------------------------------------------------------------
module mpu_region_table_manager #(
  parameter int REGION_SLOTS = mrtm_pkg::DEF_REGION_SLOTS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // base_address, size_code, priv_access, user_access
  input  logic [1:0]  in_tuser,   // operation
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,  // status, region_index, rbar_word, rasr_word
  output logic        out_tlast   // last
);
  import mrtm_pkg::*;

  localparam int IDX_W = (REGION_SLOTS > 1) ? $clog2(REGION_SLOTS) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(REGION_SLOTS - 1);

  state_t state_r, state_nxt;

  logic [REGION_SLOTS-1:0] valid_r;
  logic [31:0] slot_base_r [REGION_SLOTS];
  logic [31:0] slot_end_r  [REGION_SLOTS];
  logic [4:0]  slot_size_r [REGION_SLOTS];
  logic [1:0]  slot_pr_r   [REGION_SLOTS];
  logic [1:0]  slot_ur_r   [REGION_SLOTS];

  logic [IDX_W-1:0] idx_r, free_idx_r, found_idx_r;
  logic             ph_r, free_found_r, ovl_r;
  op_t              op_r;
  logic [31:0]      base_r, end_r;
  logic [4:0]       size_r;
  logic [1:0]       pr_r, ur_r;

  status_t     res_status_r;
  logic [2:0]  res_idx_r;
  logic [31:0] res_rbar_r, res_rasr_r;
  logic        res_last_r;

  logic        in_acc, out_acc;
  op_t         in_op;
  logic [31:0] in_base;
  logic [4:0]  in_size;
  logic [1:0]  in_pr, in_ur;

  logic [IDX_W-1:0] idx_nx, rd_idx, free_sel;
  logic             last_slot, cur_valid, nx_valid;
  logic             scan_done, free_any, ovl_now;
  logic [31:0]      rd_base, rd_end;
  logic [4:0]       rd_size;
  logic [1:0]       rd_pr, rd_ur;

  logic [31:0]  u_a, u_b, u_c, u_sum;
  unit_flags_t  u_flags;

  logic        res_load;
  status_t     res_status;
  logic [2:0]  res_idx;
  logic [31:0] res_rbar, res_rasr;
  logic        res_last;

  logic             wr_en;
  logic [IDX_W-1:0] wr_idx;
  logic [31:0]      wr_base, wr_end;
  logic [4:0]       wr_size;
  logic [1:0]       wr_pr, wr_ur;

  assign in_op   = op_t'(in_tuser);
  assign in_base = in_tdata[31:0];
  assign in_size = in_tdata[36:32];
  assign in_pr   = in_tdata[38:37];
  assign in_ur   = in_tdata[40:39];

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = (state_r == S_OUT);
  assign in_acc     = in_tvalid && in_tready;
  assign out_acc    = out_tvalid && out_tready;
  assign out_tdata  = {3'b000, res_rasr_r, res_rbar_r, res_idx_r, res_status_r};
  assign out_tlast  = res_last_r;

  assign idx_nx    = idx_r + 1'b1;
  assign last_slot = (idx_r == LAST_IDX);
  assign cur_valid = valid_r[idx_r];
  assign nx_valid  = last_slot ? 1'b0 : valid_r[idx_nx];
  assign rd_idx    = (state_r == S_SHIFT) ? idx_nx : idx_r;

  assign rd_base = slot_base_r[rd_idx];
  assign rd_end  = slot_end_r[rd_idx];
  assign rd_size = slot_size_r[rd_idx];
  assign rd_pr   = slot_pr_r[rd_idx];
  assign rd_ur   = slot_ur_r[rd_idx];

  assign scan_done = (ph_r || !cur_valid) && last_slot;
  assign free_any  = free_found_r || (!ph_r && !cur_valid);
  assign ovl_now   = ovl_r || (cur_valid && u_flags.in_span);
  assign free_sel  = free_found_r ? free_idx_r : idx_r;

  mrtm_span_unit u_span (
    .opa   (u_a),
    .opb   (u_b),
    .opc   (u_c),
    .sum   (u_sum),
    .flags (u_flags)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          case (in_op)
            OP_ADD:    state_nxt = (in_pr < in_ur) ? S_OUT : S_END;
            OP_DEL:    state_nxt = S_FIND;
            OP_COMMIT: state_nxt = S_EMIT;
            default:   state_nxt = S_OUT;
          endcase
        end
      end
      S_END:   state_nxt = S_SCAN;
      S_SCAN:  if (scan_done) state_nxt = S_OUT;
      S_FIND: begin
        if (!cur_valid || (!u_flags.equal && last_slot)) state_nxt = S_OUT;
        else if (u_flags.equal)                         state_nxt = S_SHIFT;
      end
      S_SHIFT: if (last_slot || !nx_valid) state_nxt = S_OUT;
      S_EMIT:  state_nxt = S_OUT;
      S_OUT: begin
        if (out_acc) state_nxt = (op_r == OP_COMMIT && !res_last_r) ? S_EMIT : S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    u_a        = base_r;
    u_b        = rd_base;
    u_c        = rd_end;
    res_load   = 1'b0;
    res_status = ST_OK;
    res_idx    = 3'd0;
    res_rbar   = 32'd0;
    res_rasr   = 32'd0;
    res_last   = 1'b1;
    wr_en      = 1'b0;
    wr_idx     = idx_r;
    wr_base    = rd_base;
    wr_end     = rd_end;
    wr_size    = rd_size;
    wr_pr      = rd_pr;
    wr_ur      = rd_ur;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc && !(in_op == OP_DEL || in_op == OP_COMMIT)) begin
          if (in_op != OP_ADD || in_pr < in_ur) begin
            res_load   = 1'b1;
            res_status = ST_PARAM;
          end
        end
      end
      S_END: begin
        u_b = span_mask(size_r);
      end
      S_SCAN: begin
        if (ph_r) begin
          u_a = rd_base;
          u_b = base_r;
          u_c = end_r;
        end
        if (scan_done) begin
          res_load = 1'b1;
          if (!free_any) begin
            res_status = ST_MISS;
          end else if (ovl_now) begin
            res_status = ST_PARAM;
          end else begin
            res_idx = 3'(free_sel);
            wr_en   = 1'b1;
            wr_idx  = free_sel;
            wr_base = base_r;
            wr_end  = end_r;
            wr_size = size_r;
            wr_pr   = pr_r;
            wr_ur   = ur_r;
          end
        end
      end
      S_FIND: begin
        u_a = rd_base;
        u_b = base_r;
        if (!cur_valid || (!u_flags.equal && last_slot)) begin
          res_load   = 1'b1;
          res_status = ST_MISS;
        end
      end
      S_SHIFT: begin
        wr_en = !last_slot;
        if (last_slot || !nx_valid) begin
          res_load = 1'b1;
          res_idx  = 3'(found_idx_r);
        end
      end
      S_EMIT: begin
        res_load = 1'b1;
        res_idx  = 3'(idx_r);
        res_last = last_slot;
        if (cur_valid) begin
          res_rbar = rd_base & ~RBAR_LOW_MASK;
          res_rasr = RASR_XN | RASR_ATTR | {26'd0, rd_size, 1'b0}
                   | {5'd0, ap_code(rd_pr, rd_ur), 24'd0} | RASR_EN;
        end
      end
      S_OUT: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      valid_r      <= '0;
      idx_r        <= '0;
      ph_r         <= 1'b0;
      free_found_r <= 1'b0;
      ovl_r        <= 1'b0;
    end else begin
      state_r <= state_nxt;
      unique case (state_r)
        S_IDLE: begin
          idx_r        <= '0;
          ph_r         <= 1'b0;
          free_found_r <= 1'b0;
          ovl_r        <= 1'b0;
        end
        S_SCAN: begin
          if (!ph_r && !cur_valid && !free_found_r) free_found_r <= 1'b1;
          ovl_r <= ovl_now;
          ph_r  <= !ph_r && cur_valid;
          if ((ph_r || !cur_valid) && !last_slot) idx_r <= idx_nx;
          if (wr_en) valid_r[wr_idx] <= 1'b1;
        end
        S_FIND: begin
          if (cur_valid && !u_flags.equal && !last_slot) idx_r <= idx_nx;
        end
        S_SHIFT: begin
          valid_r[idx_r] <= nx_valid;
          if (nx_valid) idx_r <= idx_nx;
        end
        S_OUT: begin
          if (out_acc && op_r == OP_COMMIT) begin
            if (res_last_r) valid_r <= '0;
            else            idx_r   <= idx_nx;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r   <= in_op;
      base_r <= in_base;
      size_r <= in_size;
      pr_r   <= in_pr;
      ur_r   <= in_ur;
    end
    if (state_r == S_END) end_r <= u_sum;
    if (state_r == S_SCAN && !ph_r && !cur_valid && !free_found_r) free_idx_r <= idx_r;
    if (state_r == S_FIND && cur_valid && u_flags.equal) found_idx_r <= idx_r;
    if (res_load) begin
      res_status_r <= res_status;
      res_idx_r    <= res_idx;
      res_rbar_r   <= res_rbar;
      res_rasr_r   <= res_rasr;
      res_last_r   <= res_last;
    end
    if (wr_en) begin
      slot_base_r[wr_idx] <= wr_base;
      slot_end_r[wr_idx]  <= wr_end;
      slot_size_r[wr_idx] <= wr_size;
      slot_pr_r[wr_idx]   <= wr_pr;
      slot_ur_r[wr_idx]   <= wr_ur;
    end
  end

endmodule

// ===== src/mrtm_span_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrtm_span_unit
// Shared adder and range comparator used by every table scan step.
// ----------------------------------------------------------------------------
module mrtm_span_unit (
  input  logic [31:0]          opa,
  input  logic [31:0]          opb,
  input  logic [31:0]          opc,
  output logic [31:0]          sum,
  output mrtm_pkg::unit_flags_t flags
);
  import mrtm_pkg::*;

  assign sum           = opa + opb;
  assign flags.in_span = (opa >= opb) && (opa <= opc);
  assign flags.equal   = (opa == opb);

endmodule

// ===== test/mrtm_table_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrtm_table_checker
// Watches both streams of the MPU region table manager. Keeps a shadow
// region table, predicts the result items of every accepted item, and
// compares each accepted result item, field by field, with the oldest one due.
// ----------------------------------------------------------------------------
module mrtm_table_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [47:0] in_tdata,   // base_address, size_code, priv_access, user_access
  input  logic [1:0]  in_tuser,   // operation
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [71:0] out_tdata,  // status, region_index, rbar_word, rasr_word
  input  logic        out_tlast,  // last
  output int          fail_count,
  output int          items_due
);
  import mrtm_pkg::*;

  localparam int SLOTS = DEF_REGION_SLOTS;

  typedef struct packed {
    logic [1:0]  status;
    logic [2:0]  index;
    logic [31:0] rbar;
    logic [31:0] rasr;
    logic        last;
  } region_word_t;

  region_word_t words_due[$];

  logic        shadow_valid [SLOTS];
  logic [31:0] shadow_base  [SLOTS];
  logic [31:0] shadow_end   [SLOTS];
  logic [4:0]  shadow_size  [SLOTS];
  logic [1:0]  shadow_priv  [SLOTS];
  logic [1:0]  shadow_user  [SLOTS];

  int fails = 0;

  function automatic logic [2:0] access_perm(input logic [1:0] p, input logic [1:0] u);
    logic [2:0] code;
    code = AP_NONE;
    case (p)
      RT_RW: begin
        case (u)
          RT_RW:   code = AP_PRW_URW;
          RT_RO:   code = AP_PRW_URO;
          RT_NONE: code = AP_PRW;
          default: code = AP_NONE;
        endcase
      end
      RT_RO:   code = (u == RT_RO) ? AP_PRO_URO : AP_PRO;
      default: code = AP_NONE;
    endcase
    return code;
  endfunction

  // wrapped intervals hold nothing
  function automatic logic covers(input logic [31:0] a, input logic [31:0] lo,
                                  input logic [31:0] hi);
    return (a >= lo) && (a <= hi);
  endfunction

  function automatic region_word_t status_word(input logic [1:0] st, input logic [2:0] idx);
    region_word_t w;
    w        = '0;
    w.status = st;
    w.index  = idx;
    w.last   = 1'b1;
    return w;
  endfunction

  task automatic apply_region_op(input logic [1:0] op, input logic [47:0] d);
    logic [31:0]  base;
    logic [4:0]   size;
    logic [1:0]   pr;
    logic [1:0]   ur;
    logic [63:0]  wide_end;
    logic [31:0]  end_addr;
    int           free_slot;
    int           hit;
    logic         clash;
    logic         stop;
    region_word_t w;
    base = d[31:0];
    size = d[36:32];
    pr   = d[38:37];
    ur   = d[40:39];
    case (op)
      OP_ADD: begin
        free_slot = -1;
        clash     = 1'b0;
        for (int n = 0; n < SLOTS; n++)
          if (!shadow_valid[n] && free_slot < 0) free_slot = n;
        wide_end = {32'd0, base} + (64'd1 << (size + 6'd1)) - 64'd1;
        end_addr = wide_end[31:0];
        if (pr < ur) begin
          words_due.push_back(status_word(ST_PARAM, 3'd0));
        end else if (free_slot < 0) begin
          words_due.push_back(status_word(ST_MISS, 3'd0));
        end else begin
          for (int n = 0; n < SLOTS; n++)
            if (shadow_valid[n] && (covers(base, shadow_base[n], shadow_end[n]) ||
                                    covers(shadow_base[n], base, end_addr)))
              clash = 1'b1;
          if (clash) begin
            words_due.push_back(status_word(ST_PARAM, 3'd0));
          end else begin
            shadow_valid[free_slot] = 1'b1;
            shadow_base[free_slot]  = base;
            shadow_end[free_slot]   = end_addr;
            shadow_size[free_slot]  = size;
            shadow_priv[free_slot]  = pr;
            shadow_user[free_slot]  = ur;
            words_due.push_back(status_word(ST_OK, free_slot[2:0]));
          end
        end
      end
      OP_DEL: begin
        hit  = -1;
        stop = 1'b0;
        for (int n = 0; n < SLOTS; n++) begin
          if (!shadow_valid[n]) stop = 1'b1;
          if (!stop) begin
            if (hit < 0 && shadow_base[n] == base) hit = n;
            if (hit >= 0) begin
              if (n == SLOTS - 1) begin
                shadow_valid[n] = 1'b0;
              end else begin
                shadow_valid[n] = shadow_valid[n+1];
                shadow_base[n]  = shadow_base[n+1];
                shadow_end[n]   = shadow_end[n+1];
                shadow_size[n]  = shadow_size[n+1];
                shadow_priv[n]  = shadow_priv[n+1];
                shadow_user[n]  = shadow_user[n+1];
              end
            end
          end
        end
        if (hit >= 0) words_due.push_back(status_word(ST_OK, hit[2:0]));
        else          words_due.push_back(status_word(ST_MISS, 3'd0));
      end
      OP_COMMIT: begin
        for (int n = 0; n < SLOTS; n++) begin
          w       = '0;
          w.index = n[2:0];
          w.last  = (n == SLOTS - 1);
          if (shadow_valid[n]) begin
            w.rbar = shadow_base[n] & ~RBAR_LOW_MASK;
            w.rasr = RASR_XN | RASR_ATTR | {26'd0, shadow_size[n], 1'b0} |
                     {5'd0, access_perm(shadow_priv[n], shadow_user[n]), 24'd0} | RASR_EN;
          end
          words_due.push_back(w);
        end
        for (int n = 0; n < SLOTS; n++) shadow_valid[n] = 1'b0;
      end
      default: words_due.push_back(status_word(ST_PARAM, 3'd0));
    endcase
  endtask

  always @(posedge clk) begin
    region_word_t got;
    region_word_t want;
    if (!rst_n) begin
      for (int n = 0; n < SLOTS; n++) shadow_valid[n] = 1'b0;
      words_due.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        got.status = out_tdata[1:0];
        got.index  = out_tdata[4:2];
        got.rbar   = out_tdata[36:5];
        got.rasr   = out_tdata[68:37];
        got.last   = out_tlast;
        if (words_due.size() == 0) begin
          fails++;
          $display("%0t: result item with none due: tdata %h tlast %b",
                   $time, out_tdata, out_tlast);
        end else begin
          want = words_due.pop_front();
          if (got !== want) begin
            fails++;
            if (got.status !== want.status)
              $display("%0t: status expected %0d, got %0d", $time, want.status, got.status);
            if (got.index !== want.index)
              $display("%0t: region_index expected %0d, got %0d",
                       $time, want.index, got.index);
            if (got.rbar !== want.rbar)
              $display("%0t: rbar_word expected %h, got %h", $time, want.rbar, got.rbar);
            if (got.rasr !== want.rasr)
              $display("%0t: rasr_word expected %h, got %h", $time, want.rasr, got.rasr);
            if (got.last !== want.last)
              $display("%0t: last expected %b, got %b", $time, want.last, got.last);
          end
        end
      end
      if (in_tvalid && in_tready) apply_region_op(in_tuser, in_tdata);
    end
    items_due  <= words_due.size();
    fail_count <= fails;
  end

endmodule

// ===== test/mpu_region_table_manager_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpu_region_table_manager_tb
// Drives add, delete and commit items into the region table manager: a
// directed run over table full, overlap, inverted rights, wrapping spans and
// odd rights codes, then random traffic in phases of sender and receiver
// idling. The checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module mpu_region_table_manager_tb;
  import mrtm_pkg::*;

  localparam int         LIMIT_CYCLES = 400000;
  localparam int         PHASE_ITEMS  = 31;
  localparam logic [1:0] OP_UNDEFINED = 2'd3;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata   = '0;
  logic [1:0]  in_tuser   = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [71:0] out_tdata;
  logic        out_tlast;

  int fail_count;
  int items_due;
  int cycle_count = 0;
  int idle_pct    = 0;
  int stall_pct   = 0;

  logic [31:0] recent_bases[$];

  mpu_region_table_manager dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  mrtm_table_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .fail_count(fail_count),
    .items_due (items_due)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    out_tready  <= ($urandom_range(99) >= stall_pct);
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic send_item(input logic [1:0] op, input logic [31:0] base,
                           input logic [4:0] size, input logic [1:0] pr, input logic [1:0] ur);
    if ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {7'd0, ur, pr, size, base};
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic random_item();
    int          pick;
    logic [31:0] base;
    logic [4:0]  size;
    logic [1:0]  pr;
    logic [1:0]  ur;
    pick = $urandom_range(99);
    base = $urandom();
    size = 5'($urandom_range(31));
    pr   = 2'($urandom_range(3));
    ur   = 2'($urandom_range(3));
    if (pick < 50) begin
      size = 5'($urandom_range(12, 4));
      pr   = 2'($urandom_range(2));
      ur   = 2'($urandom_range(pr));
      recent_bases.push_back(base);
      if (recent_bases.size() > 16) void'(recent_bases.pop_front());
      send_item(OP_ADD, base, size, pr, ur);
    end else if (pick < 58) begin
      // lands next to or inside an earlier region
      if (recent_bases.size() > 0) begin
        base = recent_bases[$urandom_range(recent_bases.size() - 1)];
        if ($urandom_range(1)) base = base + $urandom_range(63);
        else                   base = base - $urandom_range(63);
      end
      size = 5'($urandom_range(8, 4));
      pr   = 2'($urandom_range(2));
      ur   = 2'($urandom_range(pr));
      send_item(OP_ADD, base, size, pr, ur);
    end else if (pick < 66) begin
      send_item(OP_ADD, base, size, pr, ur);
    end else if (pick < 84) begin
      if (recent_bases.size() > 0)
        base = recent_bases[$urandom_range(recent_bases.size() - 1)];
      send_item(OP_DEL, base, size, pr, ur);
    end else if (pick < 88) begin
      send_item(OP_DEL, base, size, pr, ur);
    end else if (pick < 96) begin
      send_item(OP_COMMIT, base, size, pr, ur);
    end else begin
      send_item(OP_UNDEFINED, base, size, pr, ur);
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // fill the table, hitting overlap, inverted rights and full
    send_item(OP_ADD, 32'h1000_0000, 5'd4,  RT_RW, RT_RW);
    send_item(OP_ADD, 32'h1000_0010, 5'd4,  RT_RW, RT_RW);
    send_item(OP_ADD, 32'h0FFF_FFF0, 5'd5,  RT_RW, RT_RO);
    send_item(OP_ADD, 32'h8000_0000, 5'd4,  RT_RO, RT_RW);
    send_item(OP_ADD, 32'h2000_0000, 5'd31, 2'd3,  2'd3);
    send_item(OP_ADD, 32'h0000_0000, 5'd0,  RT_RW, RT_RO);
    send_item(OP_ADD, 32'hFFFF_FFE0, 5'd4,  RT_RW, RT_NONE);
    send_item(OP_ADD, 32'h3000_0000, 5'd10, RT_RO, RT_RO);
    send_item(OP_ADD, 32'h4000_0000, 5'd10, RT_RO, RT_NONE);
    send_item(OP_ADD, 32'h5000_0000, 5'd6,  RT_NONE, RT_NONE);
    send_item(OP_ADD, 32'h6000_0007, 5'd4,  2'd3,  RT_NONE);
    send_item(OP_ADD, 32'h7000_0000, 5'd4,  RT_RW, RT_RW);
    send_item(OP_COMMIT, 32'h0, 5'd0, RT_NONE, RT_NONE);
    // delete paths
    send_item(OP_DEL, 32'h0000_1234, 5'd4, RT_NONE, RT_NONE);
    send_item(OP_ADD, 32'h0000_0100, 5'd4, RT_RW, RT_RW);
    send_item(OP_ADD, 32'h0000_0200, 5'd4, RT_RW, RT_RO);
    send_item(OP_ADD, 32'h0000_0300, 5'd4, RT_RO, RT_RO);
    send_item(OP_DEL, 32'h0000_0200, 5'd4, RT_NONE, RT_NONE);
    send_item(OP_DEL, 32'h0000_0200, 5'd4, RT_NONE, RT_NONE);
    send_item(OP_UNDEFINED, 32'hFFFF_FFFF, 5'd31, 2'd3, 2'd3);
    send_item(OP_COMMIT, 32'hFFFF_FFFF, 5'd31, 2'd3, 2'd3);
    // top of the address space, full span
    send_item(OP_ADD, 32'hFFFF_FFFF, 5'd31, RT_RW, RT_RW);
    send_item(OP_ADD, 32'h0000_0000, 5'd31, RT_RW, RT_RW);
    send_item(OP_COMMIT, 32'h0, 5'd0, RT_NONE, RT_NONE);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0:       begin idle_pct = 0;  stall_pct = 0;  end
        1:       begin idle_pct = 54; stall_pct = 0;  end
        2:       begin idle_pct = 0;  stall_pct = 54; end
        default: begin idle_pct = 23; stall_pct = 23; end
      endcase
      repeat (PHASE_ITEMS) random_item();
    end
    send_item(OP_COMMIT, 32'h0, 5'd0, RT_NONE, RT_NONE);
    in_tvalid <= 1'b0;

    @(posedge clk);
    while (items_due != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (fail_count == 0 && items_due == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
